// ===== rtl/spsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented pool slot allocator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package spsa_pkg;

    localparam int MaxPools = 8;
    localparam int MaxSlots = 64;
    localparam int PoolW = $clog2(MaxPools);
    localparam int SlotW = $clog2(MaxSlots);
    localparam int SizeW = SlotW + 1;
    localparam int CountW = $clog2(MaxPools + 1);
    localparam logic [SizeW-1:0] FirstPoolSlots = SizeW'(4);
    localparam logic [SizeW-1:0] MaxSlotsV = SizeW'(MaxSlots);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_POOL  = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [0:0] REG_MAX_POOL_SLOTS = 1'b0;

    typedef struct packed {
        logic load;
        logic pick_pool;
        logic pick_slot;
        logic commit;
    } spsa_cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [PoolW-1:0] pool;
        logic [SlotW-1:0] slot;
    } spsa_stat_t;

endpackage

// ===== rtl/spsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences one request through load, pool pick, slot pick and commit.
// ----------------------------------------------------------------------------
module spsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output spsa_pkg::spsa_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POOL = 5'b00010,
        S_SLOT = 5'b00100,
        S_DONE = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_POOL;
            S_POOL: state_next = S_SLOT;
            S_SLOT: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign cmd.load = (state_reg == S_IDLE) && start;
    assign cmd.pick_pool = (state_reg == S_POOL);
    assign cmd.pick_slot = (state_reg == S_SLOT);
    assign cmd.commit = (state_reg == S_DONE);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> cmd.pick_pool)
        else $error("pick_pool must follow load");
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick_slot |=> cmd.commit)
        else $error("commit must follow pick_slot");

endmodule

// ===== rtl/spsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator datapath
// Pool state, bitmaps, hint registers and priority encoders.
// ----------------------------------------------------------------------------
module spsa_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spsa_pkg::spsa_cmd_t             cmd,
    input  logic                            command,
    input  logic [spsa_pkg::PoolW-1:0]      pool_index,
    input  logic [spsa_pkg::SlotW-1:0]      slot_index,
    input  logic [spsa_pkg::SizeW-1:0]      max_slots,
    output spsa_pkg::spsa_stat_t            stat
);

    localparam int NP = spsa_pkg::MaxPools;
    localparam int NS = spsa_pkg::MaxSlots;
    localparam int PW = spsa_pkg::PoolW;
    localparam int SW = spsa_pkg::SlotW;
    localparam int ZW = spsa_pkg::SizeW;
    localparam int CW = spsa_pkg::CountW;

    logic [NS-1:0] occ_reg [NP];
    logic [ZW-1:0] size_reg [NP];
    logic [ZW-1:0] used_reg [NP];
    logic [SW-1:0] shint_reg [NP];
    logic [NP-1:0] shint_ok_reg;
    logic [CW-1:0] open_reg;
    logic [PW-1:0] phint_reg;
    logic          phint_ok_reg;
    logic [ZW-1:0] next_size_reg;

    logic          cmd_reg;
    logic [PW-1:0] pin_reg;
    logic [SW-1:0] sin_reg;

    logic [PW-1:0] pool_reg;
    logic          grow_reg;
    logic          fail_reg;
    logic [SW-1:0] slot_reg;
    logic          sfail_reg;

    logic [NP-1:0] room;
    logic [NP-1:0] zero;
    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            room[i] = (CW'(i) < open_reg) && (used_reg[i] < size_reg[i]);
            zero[i] = (CW'(i) < open_reg) && (size_reg[i] == '0);
        end
    end

    logic          p_found;
    logic          p_grow;
    logic [PW-1:0] p_pool;
    logic          z_ok;
    logic [PW-1:0] z_id;
    always_comb
    begin
        p_found = 1'b0;
        p_grow = 1'b0;
        p_pool = '0;
        z_ok = 1'b0;
        z_id = '0;
        if (phint_ok_reg && room[phint_reg])
        begin
            p_found = 1'b1;
            p_pool = phint_reg;
        end
        else
        begin
            for (int i = NP - 1; i >= 0; i--)
            begin
                if (room[i])
                begin
                    p_found = 1'b1;
                    p_pool = PW'(i);
                end
            end
            for (int i = 0; i < NP; i++)
            begin
                if (zero[i] && !(|(room & ((NP'(1) << i) - NP'(1)))))
                begin
                    z_ok = 1'b1;
                    z_id = PW'(i);
                end
            end
            if (!p_found && z_ok)
            begin
                p_found = 1'b1;
                p_grow = 1'b1;
                p_pool = z_id;
            end
        end
    end

    logic [ZW-1:0] cur_size;
    logic [NS-1:0] cur_map;
    logic          s_found;
    logic [SW-1:0] s_slot;
    always_comb
    begin
        cur_size = grow_reg ? ((next_size_reg > spsa_pkg::MaxSlotsV) ? spsa_pkg::MaxSlotsV
                                                                   : next_size_reg)
                            : size_reg[pool_reg];
        cur_map = grow_reg ? '0 : occ_reg[pool_reg];
        s_found = 1'b0;
        s_slot = '0;
        if ((grow_reg || shint_ok_reg[pool_reg]) &&
            (ZW'(grow_reg ? '0 : shint_reg[pool_reg]) < cur_size) &&
            !cur_map[grow_reg ? SW'(0) : shint_reg[pool_reg]])
        begin
            s_found = 1'b1;
            s_slot = grow_reg ? '0 : shint_reg[pool_reg];
        end
        else
        begin
            for (int i = NS - 1; i >= 0; i--)
            begin
                if ((ZW'(i) < cur_size) && !cur_map[i])
                begin
                    s_found = 1'b1;
                    s_slot = SW'(i);
                end
            end
        end
    end

    logic bad_free;
    assign bad_free = (CW'(pin_reg) >= open_reg) || (ZW'(sin_reg) >= size_reg[pin_reg]) ||
                      !occ_reg[pin_reg][sin_reg];

    logic [ZW:0] dbl;
    assign dbl = {next_size_reg, 1'b0};

    logic [ZW-1:0] nused;
    logic          nxt_ok;
    logic [SW-1:0] nxt_slot;
    logic [PW:0]   pool_up;
    assign nused = (grow_reg ? '0 : used_reg[pool_reg]) + ZW'(1);
    assign nxt_slot = slot_reg + SW'(1);
    assign nxt_ok = (ZW'(slot_reg) + ZW'(1) < cur_size) && !cur_map[nxt_slot];
    assign pool_up = {1'b0, pool_reg} + (PW+1)'(1);

    logic up_room;
    always_comb
    begin
        up_room = 1'b0;
        if (pool_up < (PW+1)'(NP))
            up_room = room[pool_up[PW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            pin_reg <= pool_index;
            sin_reg <= slot_index;
        end
        if (cmd.pick_pool)
        begin
            pool_reg <= p_found ? p_pool : PW'(open_reg);
            grow_reg <= p_grow || !p_found;
            fail_reg <= !p_found && (open_reg >= CW'(NP));
        end
        if (cmd.pick_slot)
        begin
            slot_reg <= s_slot;
            sfail_reg <= !s_found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && cmd_reg == spsa_pkg::CMD_ALLOC && !fail_reg && !sfail_reg)
        begin
            occ_reg[pool_reg] <= cur_map | (NS'(1) << slot_reg);
        end
        else if (cmd.commit && cmd_reg == spsa_pkg::CMD_FREE && !bad_free)
        begin
            occ_reg[pin_reg][sin_reg] <= 1'b0;
        end
        if (cmd.commit && cmd_reg == spsa_pkg::CMD_ALLOC && !fail_reg && !sfail_reg)
            shint_reg[pool_reg] <= nxt_slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
            begin
                size_reg[i] <= '0;
                used_reg[i] <= '0;
            end
            shint_ok_reg <= '0;
            open_reg <= '0;
            phint_reg <= '0;
            phint_ok_reg <= 1'b0;
            next_size_reg <= spsa_pkg::FirstPoolSlots;
            stat <= '0;
        end
        else if (cmd.commit)
        begin
            stat <= '0;
            if (cmd_reg == spsa_pkg::CMD_ALLOC)
            begin
                if (fail_reg || sfail_reg)
                    stat.status <= spsa_pkg::ST_NO_POOL;
                else
                begin
                    if (grow_reg)
                    begin
                        next_size_reg <= (dbl > {1'b0, max_slots}) ? max_slots : dbl[ZW-1:0];
                        if (CW'(pool_reg) == open_reg)
                            open_reg <= open_reg + CW'(1);
                        size_reg[pool_reg] <= cur_size;
                    end
                    used_reg[pool_reg] <= nused;
                    if (nused >= cur_size)
                    begin
                        phint_ok_reg <= up_room;
                        if (up_room)
                            phint_reg <= pool_up[PW-1:0];
                    end
                    else
                    begin
                        phint_ok_reg <= 1'b1;
                        phint_reg <= pool_reg;
                    end
                    shint_ok_reg[pool_reg] <= nxt_ok;
                    stat.pool <= pool_reg;
                    stat.slot <= slot_reg;
                end
            end
            else if (bad_free)
                stat.status <= spsa_pkg::ST_BAD_FREE;
            else
            begin
                used_reg[pin_reg] <= used_reg[pin_reg] - ZW'(1);
                if (used_reg[pin_reg] == ZW'(1))
                begin
                    size_reg[pin_reg] <= '0;
                    shint_ok_reg[pin_reg] <= 1'b0;
                    if (phint_ok_reg && phint_reg == pin_reg)
                        phint_ok_reg <= 1'b0;
                end
                else if (phint_ok_reg && pin_reg < phint_reg)
                    phint_reg <= pin_reg;
            end
        end
    end

    a_open: assert property (@(posedge clk) disable iff (!rst_n) open_reg <= CW'(NP))
        else $error("pools_open overflow");
    a_used: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg[phint_reg] <= size_reg[phint_reg])
        else $error("used above size");
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        next_size_reg >= spsa_pkg::FirstPoolSlots)
        else $error("next size below minimum");

endmodule

// ===== rtl/segmented_pool_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented pool slot allocator
// Hands out and returns pool/slot handles over up to eight growing sub-pools.
// ----------------------------------------------------------------------------
// A word taken while idle goes through the load, pool pick, slot pick and
// commit steps of the controller. done is registered from commit, and busy
// drops so the next word can be taken; no new word is taken while busy.
// The receiver cannot stall the result.
// Reset clears all pools, hints and counts and sets the slot cap to 64.
module segmented_pool_slot_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [2:0]  pool_index,
    input  logic [5:0]  slot_index,
    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  granted_pool,
    output logic [5:0]  granted_slot,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    spsa_pkg::spsa_cmd_t  cmd;
    spsa_pkg::spsa_stat_t stat;
    logic [spsa_pkg::SizeW-1:0] max_reg;
    logic [6:0] wv;
    logic done_reg;

    assign pready = 1'b1;
    assign wv = pwdata[6:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= spsa_pkg::MaxSlotsV;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (psel && penable && pwrite && paddr[1] == spsa_pkg::REG_MAX_POOL_SLOTS &&
                paddr[0] == 1'b0)
            begin
                if (wv < 7'd4)
                    max_reg <= spsa_pkg::SizeW'(4);
                else if (wv > 7'(spsa_pkg::MaxSlots))
                    max_reg <= spsa_pkg::MaxSlotsV;
                else
                    max_reg <= spsa_pkg::SizeW'(wv);
            end
        end
    end

    assign prdata = (paddr == 2'd0) ? 32'(max_reg) : '0;

    spsa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd)
    );

    spsa_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .command(command),
        .pool_index(pool_index), .slot_index(slot_index),
        .max_slots(max_reg), .stat(stat)
    );

    assign done = done_reg;
    assign status = stat.status;
    assign granted_pool = stat.pool;
    assign granted_slot = stat.slot;

endmodule
